>>> rtl/core/ptwa_pkg.sv
// Package for the page table with aging: widths, operation codes and the
// word and table entry layouts. No dependencies.
`timescale 1ns / 1ps

package ptwa_pkg;

  localparam int unsigned NumPages  = 256;
  localparam int unsigned NumFrames = 64;
  localparam int unsigned FuncW     = 3;
  localparam int unsigned PageW     = 8;
  localparam int unsigned FrameW    = $clog2(NumFrames);
  localparam int unsigned AgeW      = 8;

  localparam logic [AgeW-1:0] AgeTop = 8'h80;

  typedef enum logic [FuncW-1:0] {
    FnQuery = 3'd0,
    FnRef   = 3'd1,
    FnMap   = 3'd2,
    FnInval = 3'd3,
    FnTick  = 3'd4
  } func_e;

  typedef struct packed {
    logic [FuncW-1:0]  func;
    logic [PageW-1:0]  page;
    logic [FrameW-1:0] frame;
  } req_t;

  typedef struct packed {
    logic              present;
    logic [FrameW-1:0] frame_number;
    logic [AgeW-1:0]   age;
  } rsp_t;

  typedef struct packed {
    logic              valid;
    logic              refd;
    logic [AgeW-1:0]   age;
    logic [FrameW-1:0] frame;
  } entry_t;

endpackage

>>> rtl/core/ptwa_chan_if.sv
// Valid/ready channel carrying one payload word of a given type.
// No dependencies; the payload type is set where the channel is instantiated.
`timescale 1ns / 1ps

interface ptwa_chan_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

>>> rtl/core/ptwa_ram.sv
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
`timescale 1ns / 1ps

module ptwa_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/page_table_with_aging.sv
// Page table with aging counters (approximate LRU), top level.
// Uses ptwa_pkg, ptwa_chan_if and ptwa_ram.
//
// Usage:
//   req_i carries one operation word (func, page, frame); rsp_o carries one
//   result word (present, frame_number, age), produced for a query only.
//   All state sits in one RAM of NUM_PAGES entries; a reference reads the
//   entry, modifies it and writes it back, a query only reads it.
//   Query and reference run in two steps: accept and RAM read, then result
//   or write back. Map and invalidate write at the accept edge, so the next
//   word can be taken in the next cycle. An aging tick sweeps the whole
//   RAM, one entry per cycle with read and write back overlapped; the
//   next word is taken once the last entry is written back.
//   A query result sits in an output register; the next word is accepted
//   while it waits. A second query stalls at its write back into that
//   register until the receiver takes the first result.
//   After reset a clearing pass writes every RAM entry to zero, with
//   req_i.ready low. Codes 5 to 7 and out-of-range pages for
//   reference, map or invalidate are dropped; a query beyond the table
//   returns all zero.
`timescale 1ns / 1ps

module page_table_with_aging #(
  parameter int unsigned NUM_PAGES = ptwa_pkg::NumPages
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ptwa_chan_if.sink   req_i,
  ptwa_chan_if.source rsp_o
);

  import ptwa_pkg::*;

  localparam int unsigned PageAw = $clog2(NUM_PAGES);
  localparam int unsigned EntryW = $bits(entry_t);
  localparam logic [PageAw-1:0] LastPage = PageAw'(NUM_PAGES - 1);

  localparam logic [2:0] StClear   = 3'd0;
  localparam logic [2:0] StIdle    = 3'd1;
  localparam logic [2:0] StRead    = 3'd2;
  localparam logic [2:0] StTick    = 3'd3;
  localparam logic [2:0] StTickEnd = 3'd4;

  logic [2:0]        state_q, state_d;
  logic [PageAw-1:0] cnt_q, cnt_d;
  logic              wb_q, wb_d;
  logic [PageAw-1:0] wb_addr_q, wb_addr_d;

  logic [FuncW-1:0]  op_func_q;
  logic [PageAw-1:0] op_addr_q;
  logic              op_inside_q;

  logic              rsp_valid_q, rsp_valid_d;
  rsp_t              rsp_q, rsp_d;

  logic              accept;
  logic              req_inside;
  logic [PageAw-1:0] req_addr;

  logic              ram_we, ram_re;
  logic [PageAw-1:0] ram_waddr, ram_raddr;
  entry_t            ram_wdata, ram_rdata, aged;
  logic              rsp_free;

  assign req_i.ready = (state_q == StIdle);
  assign accept      = req_i.valid && req_i.ready;
  assign req_inside  = 32'(req_i.payload.page) < NUM_PAGES;
  assign req_addr    = PageAw'(req_i.payload.page);
  assign rsp_free    = !rsp_valid_q || rsp_o.ready;

  // aging step for a valid entry: shift right, reference bit into the top, clear the reference
  always_comb begin
    aged = ram_rdata;
    if (ram_rdata.valid) begin
      aged.age  = {ram_rdata.refd, ram_rdata.age[AgeW-1:1]};
      aged.refd = 1'b0;
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    wb_d        = 1'b0;
    wb_addr_d   = wb_addr_q;
    rsp_valid_d = rsp_valid_q;
    rsp_d       = rsp_q;
    ram_we      = 1'b0;
    ram_waddr   = cnt_q;
    ram_wdata   = '0;
    ram_re      = 1'b0;
    ram_raddr   = req_addr;

    if (rsp_valid_q && rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end

    unique case (state_q)
      StClear: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_q;
        cnt_d     = cnt_q + 1'b1;
        if (cnt_q == LastPage) begin
          cnt_d   = '0;
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (accept) begin
          case (req_i.payload.func)
            FnQuery: begin
              ram_re  = req_inside;
              state_d = StRead;
            end
            FnRef: begin
              if (req_inside) begin
                ram_re  = 1'b1;
                state_d = StRead;
              end
            end
            FnMap: begin
              ram_we          = req_inside;
              ram_waddr       = req_addr;
              ram_wdata.valid = 1'b1;
              ram_wdata.refd  = 1'b1;
              ram_wdata.age   = AgeTop;
              ram_wdata.frame = req_i.payload.frame;
            end
            FnInval: begin
              ram_we    = req_inside;
              ram_waddr = req_addr;
            end
            FnTick: begin
              cnt_d   = '0;
              state_d = StTick;
            end
            default: ;
          endcase
        end
      end
      StRead: begin
        if (op_func_q == FnQuery) begin
          // hold until the output register can take the word
          if (rsp_free) begin
            rsp_valid_d = 1'b1;
            if (op_inside_q && ram_rdata.valid) begin
              rsp_d.present      = 1'b1;
              rsp_d.frame_number = ram_rdata.frame;
              rsp_d.age          = ram_rdata.age;
            end else begin
              rsp_d = '0;
            end
            state_d = StIdle;
          end
        end else begin
          ram_we         = 1'b1;
          ram_waddr      = op_addr_q;
          ram_wdata      = ram_rdata;
          ram_wdata.refd = 1'b1;
          state_d        = StIdle;
        end
      end
      StTick: begin
        ram_re    = 1'b1;
        ram_raddr = cnt_q;
        wb_d      = 1'b1;
        wb_addr_d = cnt_q;
        cnt_d     = cnt_q + 1'b1;
        if (wb_q) begin
          ram_we    = 1'b1;
          ram_waddr = wb_addr_q;
          ram_wdata = aged;
        end
        if (cnt_q == LastPage) begin
          cnt_d   = '0;
          state_d = StTickEnd;
        end
      end
      StTickEnd: begin
        ram_we    = 1'b1;
        ram_waddr = wb_addr_q;
        ram_wdata = aged;
        state_d   = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      cnt_q       <= '0;
      wb_q        <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      wb_q        <= wb_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wb_addr_q <= wb_addr_d;
    rsp_q     <= rsp_d;
    if (accept) begin
      op_func_q   <= req_i.payload.func;
      op_addr_q   <= req_addr;
      op_inside_q <= req_inside;
    end
  end

  assign rsp_o.valid   = rsp_valid_q;
  assign rsp_o.payload = rsp_q;

  ptwa_ram #(
    .Width (EntryW),
    .Depth (NUM_PAGES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

>>> tb/sv/testbench.sv
// Testbench for page_table_with_aging: directed, back-pressure and random operation streams.
// A shadow page table predicts every lookup word, and each received word is compared with it.
// Depends on ptwa_pkg, ptwa_chan_if and the page_table_with_aging RTL.
`timescale 1ns / 1ps

module testbench;
  import ptwa_pkg::*;

  localparam int unsigned SweepCycles   = NumPages + 1;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned HoldCycles    = 200;

  localparam logic [FuncW-1:0] FnSpareFirst = 3'd5;
  localparam logic [FuncW-1:0] FnSpareLast  = 3'd7;

  logic clk_i = 1'b0;
  logic rst_ni;

  ptwa_chan_if #(.payload_t(req_t)) req_if ();
  ptwa_chan_if #(.payload_t(rsp_t)) rsp_if ();

  page_table_with_aging DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if.sink),
    .rsp_o  (rsp_if.source)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Shadow copy of the page table
  logic              tbl_valid [NumPages];
  logic [FrameW-1:0] tbl_frame [NumPages];
  logic              tbl_refd  [NumPages];
  logic [AgeW-1:0]   tbl_age   [NumPages];

  rsp_t lookup_q[$];

  int errors       = 0;
  int n_words      = 0;
  int n_queries    = 0;
  int n_ticks      = 0;
  int rsp_hold_req = 0;
  int stall_cycles = 0;
  bit idle_on      = 1'b1;

  function automatic req_t mk_word(input logic [FuncW-1:0] fn, input int pg, input int fr);
    req_t w;
    w.func  = fn;
    w.page  = pg[PageW-1:0];
    w.frame = fr[FrameW-1:0];
    return w;
  endfunction

  // Apply one accepted word to the shadow table; queue the lookup result if any.
  function automatic void apply_page_op(input req_t w);
    rsp_t r;
    case (w.func)
      FnQuery: begin
        r.present      = tbl_valid[w.page];
        r.frame_number = tbl_valid[w.page] ? tbl_frame[w.page] : '0;
        r.age          = tbl_age[w.page];
        lookup_q.push_back(r);
        n_queries++;
      end
      FnRef: tbl_refd[w.page] = 1'b1;
      FnMap: begin
        tbl_valid[w.page] = 1'b1;
        tbl_frame[w.page] = w.frame;
        tbl_refd[w.page]  = 1'b1;
        tbl_age[w.page]   = AgeTop;
      end
      FnInval: begin
        tbl_valid[w.page] = 1'b0;
        tbl_frame[w.page] = '0;
        tbl_refd[w.page]  = 1'b0;
        tbl_age[w.page]   = '0;
      end
      FnTick: begin
        for (int i = 0; i < NumPages; i++) begin
          if (tbl_valid[i]) begin
            tbl_age[i]  = {tbl_refd[i], tbl_age[i][AgeW-1:1]};
            tbl_refd[i] = 1'b0;
          end
        end
        n_ticks++;
      end
      default: ;
    endcase
  endfunction

  // Offer one word; valid stays high afterwards so back-to-back words need no gap.
  task automatic send_word(input req_t w);
    int gap;
    gap = idle_on ? $urandom_range(0, 3) : 0;
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid   <= 1'b1;
    req_if.payload <= w;
    do @(posedge clk_i); while (!req_if.ready);
    apply_page_op(w);
    if (w.func <= FnTick) n_words++;
  endtask

  task automatic wait_drained();
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (lookup_q.size() != 0);
  endtask

  task automatic test_directed();
    send_word(mk_word(FnQuery, 0, 0));
    send_word(mk_word(FnMap, 0, 0));
    send_word(mk_word(FnMap, 255, 63));
    send_word(mk_word(FnQuery, 0, 63));
    send_word(mk_word(FnQuery, 255, 0));
    send_word(mk_word(FnTick, 0, 0));
    send_word(mk_word(FnQuery, 255, 0));
    send_word(mk_word(FnTick, 255, 63));
    send_word(mk_word(FnRef, 255, 0));
    send_word(mk_word(FnTick, 0, 0));
    send_word(mk_word(FnQuery, 0, 0));
    send_word(mk_word(FnQuery, 255, 0));
    // remap of a live page restarts its age
    send_word(mk_word(FnMap, 0, 42));
    send_word(mk_word(FnQuery, 0, 21));
    // reference on an unmapped page must not age it
    send_word(mk_word(FnRef, 170, 0));
    send_word(mk_word(FnTick, 0, 0));
    send_word(mk_word(FnQuery, 170, 0));
    send_word(mk_word(FnMap, 85, 21));
    send_word(mk_word(FnInval, 85, 42));
    send_word(mk_word(FnQuery, 85, 0));
    for (int fn = FnSpareFirst; fn <= FnSpareLast; fn++) begin
      send_word(mk_word(FuncW'(fn), 0, 63));
    end
    send_word(mk_word(FnQuery, 0, 0));
    wait_drained();
  endtask

  // Stall the receiver for a long stretch so lookups pile up and the input stalls.
  task automatic test_backpressure();
    int base;
    base    = $urandom_range(0, NumPages - 8);
    idle_on = 1'b0;
    rsp_hold_req = HoldCycles;
    for (int k = 0; k < 24; k++) begin
      if (k < 4) send_word(mk_word(FnMap, base + k, $urandom_range(0, 63)));
      else       send_word(mk_word(FnQuery, base + $urandom_range(0, 7), 0));
    end
    wait_drained();
    idle_on = 1'b1;
  endtask

  task automatic test_random_ops(input int count);
    int start, base, roll, pg;
    logic [FuncW-1:0] fn;
    start = n_words;
    base  = 0;
    for (int k = 0; n_words - start < count; k++) begin
      if (k % 64 == 0) begin
        idle_on = ($urandom_range(0, 3) != 0);
        base    = $urandom_range(0, NumPages - 16);
      end
      // mostly a small page window so lookups hit mapped pages
      pg   = ($urandom_range(0, 3) != 0) ? base + $urandom_range(0, 15)
                                         : $urandom_range(0, NumPages - 1);
      roll = $urandom_range(0, 99);
      if      (roll < 38) fn = FnQuery;
      else if (roll < 53) fn = FnRef;
      else if (roll < 75) fn = FnMap;
      else if (roll < 87) fn = FnInval;
      else if (roll < 92) fn = FnTick;
      else                fn = logic'($urandom_range(FnSpareFirst, FnSpareLast)) ?
                                 FuncW'($urandom_range(FnSpareFirst, FnSpareLast)) :
                                 FnSpareLast;
      send_word(mk_word(fn, pg, $urandom_range(0, 63)));
    end
    wait_drained();
  endtask

  // Compare each received word with the oldest prediction
  always @(posedge clk_i) begin : check_lookups
    rsp_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (lookup_q.size() == 0) begin
        $error("result word with no lookup pending: %p", rsp_if.payload);
        errors++;
      end else begin
        want = lookup_q.pop_front();
        if (rsp_if.payload.present !== want.present) begin
          $error("present: expected %0d, got %0d", want.present, rsp_if.payload.present);
          errors++;
        end
        if (rsp_if.payload.frame_number !== want.frame_number) begin
          $error("frame_number: expected %0d, got %0d",
                 want.frame_number, rsp_if.payload.frame_number);
          errors++;
        end
        if (rsp_if.payload.age !== want.age) begin
          $error("age: expected 0x%02h, got 0x%02h", want.age, rsp_if.payload.age);
          errors++;
        end
      end
    end
  end

  // Receiver: random stall per word, plus an occasional long hold-off
  initial begin : receiver
    int stall;
    int hold;
    stall = 0;
    hold  = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni) begin
        if (rsp_hold_req > 0) begin
          hold         = rsp_hold_req;
          rsp_hold_req = 0;
        end
        if (hold > 0) begin
          hold--;
          rsp_if.ready <= 1'b0;
        end else if (stall > 0) begin
          stall--;
          rsp_if.ready <= (stall == 0);
        end else if (!rsp_if.ready || rsp_if.valid) begin
          stall = idle_on ? $urandom_range(0, 3) : 0;
          rsp_if.ready <= (stall == 0);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WatchdogLimit) begin
      $error("no handshake for %0d cycles", stall_cycles);
      $display("status: fail");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    rst_ni = 1'b0;
    req_if.valid   <= 1'b0;
    req_if.payload <= '0;
    for (int i = 0; i < NumPages; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_frame[i] = '0;
      tbl_refd[i]  = 1'b0;
      tbl_age[i]   = '0;
    end
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_backpressure();
    test_random_ops(500);
    test_backpressure();
    test_random_ops(500);

    // let any sweep still in flight finish before closing
    repeat (SweepCycles + 8) @(posedge clk_i);
    $display("ran %0d words: %0d lookups checked, %0d aging sweeps", n_words, n_queries, n_ticks);
    $display("directed corner cases, two long receiver hold-offs and random page windows");
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/ptwa_pkg.sv
rtl/core/ptwa_chan_if.sv
rtl/core/ptwa_ram.sv
rtl/core/page_table_with_aging.sv
tb/sv/testbench.sv
